/* rtl/core/csap_pkg.sv */
`default_nettype none

package csap_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int COUNTER_BITS = 17;

    localparam int ACC_W     = 36;
    localparam int WIN_W     = 17;
    localparam int LEVEL_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int CUR_W     = 25;
    localparam int PEAKS_W   = 4;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;

    localparam int DIV_W  = COUNTER_BITS + 1;
    localparam int NUM_W  = ACC_W + 5;
    localparam int STEP_W = $clog2(NUM_W + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_DATA_W  = LEVEL_W + CUR_W;
    localparam int M_TDATA_W = ((M_DATA_W + 7) / 8) * 8;

    localparam int INV_SQRT2_Q16 = 46341;
    localparam int INV_W         = 17;
    localparam int DC_SHIFT      = 8;
    localparam int AC_SHIFT      = 24;
    localparam int P1_W          = LEVEL_W + 1 + GAIN_W + 1;
    localparam int P2_W          = P1_W + INV_W;

    localparam int LEVEL_MAX = ((2 ** SAMPLE_BITS) - 1) * 16;

    localparam logic [CFG_IDX_W-1:0] REG_AC_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DC_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AC_OFFSET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DC_WINDOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AC_WINDOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_WINDOWS = 3'd6;

    localparam logic               RST_AC_MODE      = 1'b1;
    localparam logic [LEVEL_W-1:0] RST_DC_OFFSET    = 16'd31722;
    localparam logic [LEVEL_W-1:0] RST_AC_OFFSET    = 16'd32144;
    localparam logic [GAIN_W-1:0]  RST_GAIN         = 16'd2176;
    localparam logic [WIN_W-1:0]   RST_DC_WINDOW    = 17'd100000;
    localparam logic [WIN_W-1:0]   RST_AC_WINDOW    = 17'd80000;
    localparam logic [PEAKS_W-1:0] RST_PEAK_WINDOWS = 4'd12;

    typedef struct packed {
        logic               ac_mode;
        logic [LEVEL_W-1:0] dc_offset;
        logic [LEVEL_W-1:0] ac_offset;
        logic [GAIN_W-1:0]  gain;
        logic [WIN_W-1:0]   dc_window;
        logic [WIN_W-1:0]   ac_window;
        logic [PEAKS_W-1:0] peak_windows;
    } cfg_t;

    typedef struct packed {
        logic [ACC_W-1:0]   sum;
        logic [DIV_W-1:0]   divisor;
        logic [LEVEL_W-1:0] offset;
        logic               rms;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [DIV_W-1:0] eff_window(input logic [WIN_W-1:0] w);
        logic [DIV_W-1:0] m;
        m = {1'b0, COUNTER_BITS'(w)};
        if (m == '0) begin
            m = {1'b1, {COUNTER_BITS{1'b0}}};
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/csap_front.sv */
`default_nettype none

module csap_front (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire csap_pkg::cfg_t                   cfg,
    input  wire logic                             clear,
    input  wire logic                             accept,
    input  wire logic [csap_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                  push,
    output csap_pkg::job_t                        job
);

    logic [csap_pkg::ACC_W-1:0]        acc_reg, acc_next;
    logic [csap_pkg::COUNTER_BITS-1:0] cnt_reg, cnt_next;
    logic [csap_pkg::SAMPLE_BITS-1:0]  peak_reg, peak_next;
    logic [csap_pkg::PEAKS_W-1:0]      pcnt_reg, pcnt_next;

    logic [csap_pkg::DIV_W-1:0]       win;
    logic [csap_pkg::DIV_W-1:0]       cnt_inc;
    logic [csap_pkg::PEAKS_W:0]       np;
    logic [csap_pkg::PEAKS_W:0]       pcnt_inc;
    logic [csap_pkg::SAMPLE_BITS-1:0] pk;
    logic [csap_pkg::ACC_W-1:0]       sum_dc;
    logic [csap_pkg::ACC_W-1:0]       sum_ac;

    always_comb begin
        win      = csap_pkg::eff_window(cfg.ac_mode ? cfg.ac_window : cfg.dc_window);
        cnt_inc  = {1'b0, cnt_reg} + csap_pkg::DIV_W'(1);
        np       = (cfg.peak_windows == '0) ? {1'b1, {csap_pkg::PEAKS_W{1'b0}}}
                                            : {1'b0, cfg.peak_windows};
        pcnt_inc = {1'b0, pcnt_reg} + (csap_pkg::PEAKS_W + 1)'(1);
        pk       = (sample > peak_reg) ? sample : peak_reg;
        sum_dc   = acc_reg + csap_pkg::ACC_W'(sample);
        sum_ac   = acc_reg + csap_pkg::ACC_W'(pk);

        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        peak_next = peak_reg;
        pcnt_next = pcnt_reg;
        push      = 1'b0;
        job       = '0;

        if (clear) begin
            acc_next  = '0;
            cnt_next  = '0;
            peak_next = '0;
            pcnt_next = '0;
        end else if (accept) begin
            if (!cfg.ac_mode) begin
                if (cnt_inc >= win) begin
                    push        = 1'b1;
                    job.sum     = sum_dc;
                    job.divisor = win;
                    job.offset  = cfg.dc_offset;
                    job.rms     = 1'b0;
                    acc_next    = '0;
                    cnt_next    = '0;
                end else begin
                    acc_next = sum_dc;
                    cnt_next = cnt_inc[csap_pkg::COUNTER_BITS-1:0];
                end
            end else if (cnt_inc < win) begin
                peak_next = pk;
                cnt_next  = cnt_inc[csap_pkg::COUNTER_BITS-1:0];
            end else begin
                cnt_next  = '0;
                peak_next = '0;
                if (pcnt_inc < np) begin
                    acc_next  = sum_ac;
                    pcnt_next = pcnt_inc[csap_pkg::PEAKS_W-1:0];
                end else begin
                    push        = 1'b1;
                    job.sum     = sum_ac;
                    job.divisor = csap_pkg::DIV_W'(np);
                    job.offset  = cfg.ac_offset;
                    job.rms     = 1'b1;
                    acc_next    = '0;
                    pcnt_next   = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            cnt_reg  <= '0;
            peak_reg <= '0;
            pcnt_reg <= '0;
        end else begin
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            peak_reg <= peak_next;
            pcnt_reg <= pcnt_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/csap_queue.sv */
`default_nettype none

module csap_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire csap_pkg::job_t        job_in,
    input  wire logic                  pop,
    output csap_pkg::job_t             job_out,
    output csap_pkg::queue_status_t    status
);

    csap_pkg::job_t mem_reg [csap_pkg::QUEUE_DEPTH];

    logic [csap_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [csap_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [csap_pkg::QCNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    function automatic logic [csap_pkg::QPTR_W-1:0] wrap_inc(
        input logic [csap_pkg::QPTR_W-1:0] p
    );
        if (p == csap_pkg::QPTR_W'(csap_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + csap_pkg::QPTR_W'(1);
    endfunction

    always_comb begin
        status.full  = (count_reg == csap_pkg::QCNT_W'(csap_pkg::QUEUE_DEPTH));
        status.empty = (count_reg == '0);
        do_push      = push && !status.full;
        do_pop       = pop && !status.empty;
        job_out      = mem_reg[rd_ptr_reg];

        wr_ptr_next = do_push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + csap_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - csap_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/csap_back.sv */
`default_nettype none

module csap_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [csap_pkg::GAIN_W-1:0]   gain,
    input  wire csap_pkg::job_t                job,
    input  wire logic                          job_valid,
    output logic                               pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [csap_pkg::LEVEL_W-1:0]       m_mean,
    output logic [csap_pkg::CUR_W-1:0]         m_current,
    output logic                               m_rms
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_MUL1 = 5'b00100,
        ST_MUL2 = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    localparam logic signed [csap_pkg::P2_W-1:0] CUR_MAX_W =
        csap_pkg::P2_W'((2 ** (csap_pkg::CUR_W - 1)) - 1);
    localparam logic signed [csap_pkg::P2_W-1:0] CUR_MIN_W =
        -csap_pkg::P2_W'(2 ** (csap_pkg::CUR_W - 1));
    localparam logic signed [csap_pkg::INV_W-1:0] INV_S =
        csap_pkg::INV_W'(csap_pkg::INV_SQRT2_Q16);
    localparam logic signed [csap_pkg::P1_W-1:0] DC_HALF =
        csap_pkg::P1_W'(2 ** (csap_pkg::DC_SHIFT - 1));
    localparam logic signed [csap_pkg::P2_W-1:0] AC_HALF =
        csap_pkg::P2_W'(2 ** (csap_pkg::AC_SHIFT - 1));

    state_t state_reg, state_next;

    logic [csap_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [csap_pkg::NUM_W-1:0]   num_reg, num_next;
    logic [csap_pkg::DIV_W-1:0]   rem_reg, rem_next;
    logic [csap_pkg::DIV_W-1:0]   div_reg, div_next;
    logic [csap_pkg::LEVEL_W-1:0] offset_reg, offset_next;
    logic                         rms_reg, rms_next;
    logic [csap_pkg::LEVEL_W-1:0] mean_reg, mean_next;
    logic signed [csap_pkg::P1_W-1:0] prod1_reg, prod1_next;
    logic signed [csap_pkg::P2_W-1:0] prod2_reg, prod2_next;

    logic                         out_valid_reg, out_valid_next;
    logic [csap_pkg::LEVEL_W-1:0] out_mean_reg, out_mean_next;
    logic [csap_pkg::CUR_W-1:0]   out_cur_reg, out_cur_next;
    logic                         out_rms_reg, out_rms_next;

    logic [csap_pkg::DIV_W:0]          rem_sh;
    logic [csap_pkg::DIV_W:0]          rem_sub;
    logic                              ge;
    logic [csap_pkg::LEVEL_W-1:0]      mean_sat;
    logic signed [csap_pkg::LEVEL_W:0] diff;
    logic signed [csap_pkg::GAIN_W:0]  gain_s;
    logic signed [csap_pkg::P1_W-1:0]  rnd_dc;
    logic signed [csap_pkg::P2_W-1:0]  rnd_ac;
    logic signed [csap_pkg::P2_W-1:0]  wide;
    logic [csap_pkg::CUR_W-1:0]        cur_sat;

    always_comb begin
        rem_sh  = {rem_reg, num_reg[csap_pkg::NUM_W-1]};
        rem_sub = rem_sh - {1'b0, div_reg};
        ge      = (rem_sh >= {1'b0, div_reg});

        mean_sat = (num_reg[csap_pkg::NUM_W-1:csap_pkg::LEVEL_W] != '0)
                   ? {csap_pkg::LEVEL_W{1'b1}} : num_reg[csap_pkg::LEVEL_W-1:0];
        diff     = $signed({1'b0, mean_sat}) - $signed({1'b0, offset_reg});
        gain_s   = $signed({1'b0, gain});

        rnd_dc = (prod1_reg + DC_HALF) >>> csap_pkg::DC_SHIFT;
        rnd_ac = (prod2_reg + AC_HALF) >>> csap_pkg::AC_SHIFT;
        wide   = rms_reg ? rnd_ac : csap_pkg::P2_W'(rnd_dc);
        if (wide > CUR_MAX_W) begin
            cur_sat = CUR_MAX_W[csap_pkg::CUR_W-1:0];
        end else if (wide < CUR_MIN_W) begin
            cur_sat = CUR_MIN_W[csap_pkg::CUR_W-1:0];
        end else begin
            cur_sat = wide[csap_pkg::CUR_W-1:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        offset_next    = offset_reg;
        rms_next       = rms_reg;
        mean_next      = mean_reg;
        prod1_next     = prod1_reg;
        prod2_next     = prod2_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_mean_next  = out_mean_reg;
        out_cur_next   = out_cur_reg;
        out_rms_next   = out_rms_reg;
        pop            = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    pop         = 1'b1;
                    num_next    = csap_pkg::NUM_W'({job.sum, 4'b0000})
                                  + csap_pkg::NUM_W'(job.divisor >> 1);
                    rem_next    = '0;
                    div_next    = job.divisor;
                    offset_next = job.offset;
                    rms_next    = job.rms;
                    step_next   = '0;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next  = ge ? rem_sub[csap_pkg::DIV_W-1:0] : rem_sh[csap_pkg::DIV_W-1:0];
                num_next  = {num_reg[csap_pkg::NUM_W-2:0], ge};
                step_next = step_reg + csap_pkg::STEP_W'(1);
                if (step_reg == csap_pkg::STEP_W'(csap_pkg::NUM_W - 1)) begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                mean_next  = mean_sat;
                prod1_next = diff * gain_s;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                prod2_next = prod1_reg * INV_S;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_mean_next  = mean_reg;
                    out_cur_next   = cur_sat;
                    out_rms_next   = rms_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        offset_reg   <= offset_next;
        rms_reg      <= rms_next;
        mean_reg     <= mean_next;
        prod1_reg    <= prod1_next;
        prod2_reg    <= prod2_next;
        out_mean_reg <= out_mean_next;
        out_cur_reg  <= out_cur_next;
        out_rms_reg  <= out_rms_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_mean    = out_mean_reg;
    assign m_current = out_cur_reg;
    assign m_rms     = out_rms_reg;

endmodule

`default_nettype wire

/* rtl/core/current_sense_average_peak_unit.sv */
// Path from the sample that completes a window to m_tvalid: the job is written into the
//   result-request queue, then the serial divider, two multiply stages, rounding and output register.
// Results are limited by the one-bit-per-cycle divider; a new job is taken only after the last result
//   is registered. Samples are taken every cycle while the two-entry result-request queue has room.
// Reset: synchronous, active low; configuration registers return to their reset values, all accumulation
//   state is cleared, the queue is emptied, the back end goes idle and the output valid flag is cleared.
`default_nettype none

module current_sense_average_peak_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [csap_pkg::S_TDATA_W-1:0]    s_tdata,   // sample
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [csap_pkg::M_TDATA_W-1:0]         m_tdata,   // mean_level, current_ma
    output logic                                   m_tuser,   // is_rms
    input  wire logic                              cfg_wr_en,
    input  wire logic [csap_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [csap_pkg::CFG_W-1:0]        cfg_wdata
);

    csap_pkg::cfg_t cfg_reg, cfg_next;
    logic           clear;

    always_comb begin
        cfg_next = cfg_reg;
        clear    = 1'b0;
        if (cfg_wr_en) begin
            clear = 1'b1;
            unique case (cfg_index)
                csap_pkg::REG_AC_MODE:      cfg_next.ac_mode      = cfg_wdata[0];
                csap_pkg::REG_DC_OFFSET:    cfg_next.dc_offset    =
                    cfg_wdata[csap_pkg::LEVEL_W-1:0];
                csap_pkg::REG_AC_OFFSET:    cfg_next.ac_offset    =
                    cfg_wdata[csap_pkg::LEVEL_W-1:0];
                csap_pkg::REG_GAIN:         cfg_next.gain         =
                    cfg_wdata[csap_pkg::GAIN_W-1:0];
                csap_pkg::REG_DC_WINDOW:    cfg_next.dc_window    =
                    cfg_wdata[csap_pkg::WIN_W-1:0];
                csap_pkg::REG_AC_WINDOW:    cfg_next.ac_window    =
                    cfg_wdata[csap_pkg::WIN_W-1:0];
                csap_pkg::REG_PEAK_WINDOWS: cfg_next.peak_windows =
                    cfg_wdata[csap_pkg::PEAKS_W-1:0];
                default:                    clear = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ac_mode      <= csap_pkg::RST_AC_MODE;
            cfg_reg.dc_offset    <= csap_pkg::RST_DC_OFFSET;
            cfg_reg.ac_offset    <= csap_pkg::RST_AC_OFFSET;
            cfg_reg.gain         <= csap_pkg::RST_GAIN;
            cfg_reg.dc_window    <= csap_pkg::RST_DC_WINDOW;
            cfg_reg.ac_window    <= csap_pkg::RST_AC_WINDOW;
            cfg_reg.peak_windows <= csap_pkg::RST_PEAK_WINDOWS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    logic                        accept;
    logic                        push;
    logic                        pop;
    csap_pkg::job_t              job_in;
    csap_pkg::job_t              job_out;
    csap_pkg::queue_status_t     qstat;
    logic [csap_pkg::LEVEL_W-1:0] mean;
    logic [csap_pkg::CUR_W-1:0]   current;

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;

    csap_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .clear   (clear),
        .accept  (accept),
        .sample  (s_tdata[csap_pkg::SAMPLE_BITS-1:0]),
        .push    (push),
        .job     (job_in)
    );

    csap_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .job_in  (job_in),
        .pop     (pop),
        .job_out (job_out),
        .status  (qstat)
    );

    csap_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gain      (cfg_reg.gain),
        .job       (job_out),
        .job_valid (!qstat.empty),
        .pop       (pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_mean    (mean),
        .m_current (current),
        .m_rms     (m_tuser)
    );

    assign m_tdata = csap_pkg::M_TDATA_W'({current, mean});

endmodule

`default_nettype wire

/* rtl/core/csap_checker.sv */
`default_nettype none

module csap_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [csap_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[csap_pkg::M_TDATA_W-1:csap_pkg::M_DATA_W] == '0)
        else $error("result padding not zero");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[csap_pkg::LEVEL_W-1:0] <= csap_pkg::LEVEL_W'(csap_pkg::LEVEL_MAX))
        else $error("mean level above largest sample level");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("outputs not quiet after reset");

endmodule

bind current_sense_average_peak_unit csap_checker u_csap_checker (.*);

`default_nettype wire

/* bench/tb.sv */
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [csap_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int    SETTLE_CYCLES  = 64;
    localparam int    WATCHDOG_LIMIT = 5000;
    localparam int    RANDOM_PHASE_ITEMS = 416;
    localparam int    WIDE_WINDOW_ITEMS  = 20;
    localparam longint CURRENT_HI = (longint'(1) << (csap_pkg::CUR_W - 1)) - 1;
    localparam longint CURRENT_LO = -(longint'(1) << (csap_pkg::CUR_W - 1));

    typedef struct packed {
        logic [csap_pkg::LEVEL_W-1:0]      level;
        logic signed [csap_pkg::CUR_W-1:0] current_ma;
        logic                              rms;
    } reading_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic [csap_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                             m_tready  = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [csap_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [csap_pkg::CFG_W-1:0]       cfg_wdata = '0;
    logic                             s_tready;
    logic                             m_tvalid;
    logic [csap_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             m_tuser;

    csap_pkg::cfg_t                   sense_cfg;
    logic [csap_pkg::ACC_W-1:0]       run_sum;
    logic [csap_pkg::WIN_W-1:0]       sample_count;
    logic [csap_pkg::SAMPLE_BITS-1:0] window_max;
    logic [csap_pkg::PEAKS_W-1:0]     peak_count;

    reading_t pending_readings[$];
    reading_t head_reading;
    int       error_count  = 0;
    int       idle_pct     = 0;
    int       stall_pct    = 0;
    int       quiet_cycles = 0;

    current_sense_average_peak_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [csap_pkg::DIV_W-1:0] span_of(
        input logic [csap_pkg::WIN_W-1:0] w
    );
        return (w == '0) ? (csap_pkg::DIV_W'(1) << csap_pkg::COUNTER_BITS)
                         : csap_pkg::DIV_W'(w);
    endfunction

    function automatic reading_t scale_reading(input longint sum, input longint divisor,
                                               input longint offset, input logic rms,
                                               input longint g);
        longint   lvl;
        longint   diff;
        longint   cur;
        reading_t r;
        lvl = (sum * 16 + divisor / 2) / divisor;
        if (lvl > 65535) begin
            lvl = 65535;
        end
        diff = lvl - offset;
        if (rms) begin
            cur = (diff * g * csap_pkg::INV_SQRT2_Q16
                   + (longint'(1) << (csap_pkg::AC_SHIFT - 1))) >>> csap_pkg::AC_SHIFT;
        end else begin
            cur = (diff * g + (longint'(1) << (csap_pkg::DC_SHIFT - 1)))
                  >>> csap_pkg::DC_SHIFT;
        end
        if (cur > CURRENT_HI) begin
            cur = CURRENT_HI;
        end
        if (cur < CURRENT_LO) begin
            cur = CURRENT_LO;
        end
        r.level      = lvl[csap_pkg::LEVEL_W-1:0];
        r.current_ma = cur[csap_pkg::CUR_W-1:0];
        r.rms        = rms;
        return r;
    endfunction

    task automatic clear_sense_state();
        run_sum      = '0;
        sample_count = '0;
        window_max   = '0;
        peak_count   = '0;
    endtask

    task automatic predict_reading(input logic [csap_pkg::SAMPLE_BITS-1:0] s);
        logic [csap_pkg::DIV_W-1:0]   win;
        logic [csap_pkg::DIV_W-1:0]   next_count;
        logic [csap_pkg::PEAKS_W:0]   peaks;
        next_count = csap_pkg::DIV_W'(sample_count) + 1'b1;
        if (!sense_cfg.ac_mode) begin
            win = span_of(sense_cfg.dc_window);
            run_sum = run_sum + s;
            if (next_count >= win) begin
                pending_readings.push_back(scale_reading(longint'(run_sum), longint'(win),
                    longint'(sense_cfg.dc_offset), 1'b0, longint'(sense_cfg.gain)));
                run_sum      = '0;
                sample_count = '0;
            end else begin
                sample_count = next_count[csap_pkg::WIN_W-1:0];
            end
        end else begin
            win   = span_of(sense_cfg.ac_window);
            peaks = (sense_cfg.peak_windows == '0)
                    ? (csap_pkg::PEAKS_W+1)'(16)
                    : (csap_pkg::PEAKS_W+1)'(sense_cfg.peak_windows);
            if (s > window_max) begin
                window_max = s;
            end
            if (next_count < win) begin
                sample_count = next_count[csap_pkg::WIN_W-1:0];
            end else begin
                sample_count = '0;
                run_sum      = run_sum + window_max;
                window_max   = '0;
                if ((csap_pkg::PEAKS_W+1)'(peak_count) + 1'b1 < peaks) begin
                    peak_count = peak_count + 1'b1;
                end else begin
                    pending_readings.push_back(scale_reading(longint'(run_sum),
                        longint'(peaks), longint'(sense_cfg.ac_offset), 1'b1,
                        longint'(sense_cfg.gain)));
                    run_sum    = '0;
                    peak_count = '0;
                end
            end
        end
    endtask

    task automatic send_sample(input logic [csap_pkg::SAMPLE_BITS-1:0] s);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= csap_pkg::S_TDATA_W'(s);
        do @(posedge aclk); while (!s_tready);
        predict_reading(s);
    endtask

    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_register(input logic [csap_pkg::CFG_IDX_W-1:0] idx,
                                input logic [csap_pkg::CFG_W-1:0] val);
        bit known;
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        known = 1'b1;
        case (idx)
            csap_pkg::REG_AC_MODE:      sense_cfg.ac_mode      = val[0];
            csap_pkg::REG_DC_OFFSET:    sense_cfg.dc_offset    = val[csap_pkg::LEVEL_W-1:0];
            csap_pkg::REG_AC_OFFSET:    sense_cfg.ac_offset    = val[csap_pkg::LEVEL_W-1:0];
            csap_pkg::REG_GAIN:         sense_cfg.gain         = val[csap_pkg::GAIN_W-1:0];
            csap_pkg::REG_DC_WINDOW:    sense_cfg.dc_window    = val[csap_pkg::WIN_W-1:0];
            csap_pkg::REG_AC_WINDOW:    sense_cfg.ac_window    = val[csap_pkg::WIN_W-1:0];
            csap_pkg::REG_PEAK_WINDOWS: sense_cfg.peak_windows = val[csap_pkg::PEAKS_W-1:0];
            default:                    known = 1'b0;
        endcase
        if (known) begin
            clear_sense_state();
        end
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic mode, input int dc_off, input int ac_off,
                                 input int g, input int dc_win, input int ac_win,
                                 input int peaks);
        settle_block();
        set_register(csap_pkg::REG_AC_MODE, csap_pkg::CFG_W'(mode));
        set_register(csap_pkg::REG_DC_OFFSET, csap_pkg::CFG_W'(dc_off));
        set_register(csap_pkg::REG_AC_OFFSET, csap_pkg::CFG_W'(ac_off));
        set_register(csap_pkg::REG_GAIN, csap_pkg::CFG_W'(g));
        set_register(csap_pkg::REG_DC_WINDOW, csap_pkg::CFG_W'(dc_win));
        set_register(csap_pkg::REG_AC_WINDOW, csap_pkg::CFG_W'(ac_win));
        set_register(csap_pkg::REG_PEAK_WINDOWS, csap_pkg::CFG_W'(peaks));
    endtask

    function automatic logic [csap_pkg::SAMPLE_BITS-1:0] pick_sample();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0) begin
            return '0;
        end else if (roll == 1) begin
            return '1;
        end
        return csap_pkg::SAMPLE_BITS'($urandom_range(4095));
    endfunction

    function automatic int pick_offset();
        int roll;
        roll = $urandom_range(7);
        if (roll == 0) begin
            return 0;
        end else if (roll == 1) begin
            return csap_pkg::LEVEL_MAX;
        end
        return $urandom_range(csap_pkg::LEVEL_MAX);
    endfunction

    function automatic int pick_gain();
        int roll;
        roll = $urandom_range(7);
        if (roll == 0) begin
            return 0;
        end else if (roll == 1) begin
            return 65535;
        end
        return $urandom_range(65535);
    endfunction

    function automatic int pick_dc_window();
        int roll;
        roll = $urandom_range(9);
        if (roll < 7) begin
            return $urandom_range(4, 1);
        end else if (roll < 9) begin
            return $urandom_range(40, 5);
        end
        return $urandom_range(70, 41);
    endfunction

    task automatic test_dc_extremes();
        load_settings(1'b0, 0, 0, 65535, 1, 1, 1);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd2048);
        load_settings(1'b0, csap_pkg::LEVEL_MAX, 0, 65535, 1, 1, 1);
        send_sample(12'd0);
        send_sample(12'd4095);
        load_settings(1'b0, 31722, 32144, 0, 3, 1, 1);
        send_sample(12'd4095);
        send_sample(12'd1);
        send_sample(12'd2);
    endtask

    task automatic test_ac_extremes();
        load_settings(1'b1, 0, 0, 65535, 1, 1, 1);
        send_sample(12'd4095);
        send_sample(12'd0);
        load_settings(1'b1, 0, csap_pkg::LEVEL_MAX, 65535, 1, 1, 1);
        send_sample(12'd0);
        send_sample(12'd4095);
    endtask

    task automatic test_sixteen_peaks();
        load_settings(1'b1, 0, 32144, 2176, 1, 1, 0);
        for (int i = 0; i < 16; i++) begin
            send_sample((i % 3 == 0) ? 12'd4095
                                     : csap_pkg::SAMPLE_BITS'($urandom_range(4095)));
        end
    endtask

    task automatic test_mode_write_clears();
        load_settings(1'b0, 0, 0, 256, 2, 2, 1);
        send_sample(12'd4095);
        settle_block();
        set_register(csap_pkg::REG_AC_MODE, csap_pkg::CFG_W'(1));
        send_sample(12'd4095);
        settle_block();
        set_register(csap_pkg::REG_AC_MODE, csap_pkg::CFG_W'(0));
        send_sample(12'd0);
        send_sample(12'd0);
    endtask

    task automatic test_spare_index_keeps_state();
        load_settings(1'b0, 0, 0, 256, 2, 1, 1);
        send_sample(12'd4095);
        settle_block();
        set_register(REG_SPARE, csap_pkg::CFG_W'($urandom_range(131071)));
        send_sample(12'd4095);
    endtask

    task automatic test_widest_windows();
        idle_pct  = 0;
        stall_pct = 0;
        load_settings(1'b0, pick_offset(), 0, pick_gain(), 0, 1, 1);
        for (int i = 0; i < WIDE_WINDOW_ITEMS; i++) begin
            send_sample(pick_sample());
        end
        load_settings(1'b1, 0, pick_offset(), pick_gain(), 131071, 131071, 1);
        for (int i = 0; i < WIDE_WINDOW_ITEMS; i++) begin
            send_sample(pick_sample());
        end
    endtask

    task automatic test_random_traffic();
        int idle_plan[4]  = '{0, 75, 0, 37};
        int stall_plan[4] = '{0, 0, 75, 37};
        int sent;
        int burst;
        int segment;
        for (int phase = 0; phase < 4; phase++) begin
            settle_block();
            idle_pct  = idle_plan[phase];
            stall_pct = stall_plan[phase];
            sent    = 0;
            segment = 0;
            while (sent < RANDOM_PHASE_ITEMS) begin
                load_settings(1'($urandom_range(1)), pick_offset(), pick_offset(),
                              pick_gain(), pick_dc_window(), $urandom_range(3, 1),
                              $urandom_range(15));
                burst = $urandom_range(80, 20);
                for (int i = 0; i < burst; i++) begin
                    if (segment == 0 && i == burst / 2) begin
                        settle_block();
                    end
                    send_sample(pick_sample());
                end
                sent += burst;
                segment++;
            end
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                $error("unexpected result: mean_level=%0d current_ma=%0d is_rms=%0b",
                       m_tdata[csap_pkg::LEVEL_W-1:0],
                       $signed(m_tdata[csap_pkg::LEVEL_W+csap_pkg::CUR_W-1:csap_pkg::LEVEL_W]),
                       m_tuser);
                error_count++;
            end else begin
                head_reading = pending_readings.pop_front();
                if (m_tdata[csap_pkg::LEVEL_W-1:0] !== head_reading.level) begin
                    $error("mean_level: expected %0d, actual %0d",
                           head_reading.level, m_tdata[csap_pkg::LEVEL_W-1:0]);
                    error_count++;
                end
                if (m_tdata[csap_pkg::LEVEL_W+csap_pkg::CUR_W-1:csap_pkg::LEVEL_W]
                    !== head_reading.current_ma) begin
                    $error("current_ma: expected %0d, actual %0d", head_reading.current_ma,
                           $signed(m_tdata[csap_pkg::LEVEL_W+csap_pkg::CUR_W-1:
                                           csap_pkg::LEVEL_W]));
                    error_count++;
                end
                if (m_tuser !== head_reading.rms) begin
                    $error("is_rms: expected %0b, actual %0b", head_reading.rms, m_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[current_sense_average_peak_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        sense_cfg.ac_mode      = csap_pkg::RST_AC_MODE;
        sense_cfg.dc_offset    = csap_pkg::RST_DC_OFFSET;
        sense_cfg.ac_offset    = csap_pkg::RST_AC_OFFSET;
        sense_cfg.gain         = csap_pkg::RST_GAIN;
        sense_cfg.dc_window    = csap_pkg::RST_DC_WINDOW;
        sense_cfg.ac_window    = csap_pkg::RST_AC_WINDOW;
        sense_cfg.peak_windows = csap_pkg::RST_PEAK_WINDOWS;
        clear_sense_state();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_dc_extremes();
        test_ac_extremes();
        test_sixteen_peaks();
        test_mode_write_clears();
        test_spare_index_keeps_state();
        test_random_traffic();
        test_widest_windows();

        settle_block();
        if (error_count == 0) begin
            $display("[current_sense_average_peak_unit] OK");
        end else begin
            $display("[current_sense_average_peak_unit] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/csap_pkg.sv
rtl/core/csap_front.sv
rtl/core/csap_queue.sv
rtl/core/csap_back.sv
rtl/core/current_sense_average_peak_unit.sv
rtl/core/csap_checker.sv
bench/tb.sv
